// ===== sv/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
// No dependencies; used by ffsa_cell and first_fit_segment_allocator.
`timescale 1ns / 1ps

package ffsa_pkg;

  localparam int ID_W             = 16;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF    = 16;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
  localparam logic [2:0] ST_NO_MEMORY    = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_ID   = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RESTART,
    OP_SEARCH,
    OP_MARK,
    OP_SPLIT,
    OP_FREE,
    OP_MERGE_PREV,
    OP_MERGE_NEXT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            kind;
    logic [ID_W-1:0] owner;
  } cmd_t;

endpackage

// ===== sv/ffsa_cell.sv =====
// One segment cell of the allocator chain: holds a segment and trades it with
// its neighbors on insert and remove shifts. Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_cell import ffsa_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter bit FIRST     = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [ADDR_BITS:0]   req_i,
  input  logic [ADDR_BITS:0]   heap_i,
  input  logic                 left_valid_i,
  input  logic                 left_free_i,
  input  logic [ADDR_BITS-1:0] left_start_i,
  input  logic [ADDR_BITS:0]   left_size_i,
  input  logic [ID_W-1:0]      left_owner_i,
  input  logic                 left_sel_i,
  input  logic                 right_valid_i,
  input  logic                 right_free_i,
  input  logic [ADDR_BITS-1:0] right_start_i,
  input  logic [ADDR_BITS:0]   right_size_i,
  input  logic [ID_W-1:0]      right_owner_i,
  input  logic                 right_sel_i,
  input  logic                 after_i,
  input  logic                 found_i,
  output logic                 valid_o,
  output logic                 free_o,
  output logic [ADDR_BITS-1:0] start_o,
  output logic [ADDR_BITS:0]   size_o,
  output logic [ID_W-1:0]      owner_o,
  output logic                 sel_o,
  output logic                 after_o,
  output logic                 found_o
);

  localparam logic [ADDR_BITS:0] HEAP_RESET = {1'b1, {ADDR_BITS{1'b0}}};

  logic                 valid_q, valid_d;
  logic                 free_q, free_d;
  logic [ADDR_BITS-1:0] start_q, start_d;
  logic [ADDR_BITS:0]   size_q, size_d;
  logic [ID_W-1:0]      owner_q, owner_d;
  logic                 sel_q, sel_d;
  logic                 hit;

  always_comb begin
    if (cmd_i.kind == KIND_FREE) begin
      hit = valid_q && (cmd_i.owner != '0) && (owner_q == cmd_i.owner);
    end else begin
      hit = valid_q && free_q && (size_q >= req_i);
    end
  end

  assign found_o = found_i | hit;
  assign after_o = after_i | sel_q;

  always_comb begin
    valid_d = valid_q;
    free_d  = free_q;
    start_d = start_q;
    size_d  = size_q;
    owner_d = owner_q;
    sel_d   = sel_q;
    case (cmd_i.op)
      OP_RESTART: begin
        valid_d = FIRST;
        free_d  = 1'b1;
        start_d = '0;
        size_d  = heap_i;
        owner_d = '0;
        sel_d   = 1'b0;
      end
      OP_SEARCH: begin
        sel_d = hit & ~found_i;
      end
      OP_MARK: begin
        if (sel_q) begin
          free_d  = 1'b0;
          owner_d = cmd_i.owner;
        end
      end
      OP_SPLIT: begin
        if (sel_q) begin
          size_d  = req_i;
          free_d  = 1'b0;
          owner_d = cmd_i.owner;
        end else if (left_sel_i) begin
          // take the tail of the split segment
          valid_d = 1'b1;
          free_d  = 1'b1;
          start_d = left_start_i + req_i[ADDR_BITS-1:0];
          size_d  = left_size_i - req_i;
          owner_d = '0;
        end else if (after_i) begin
          valid_d = left_valid_i;
          free_d  = left_free_i;
          start_d = left_start_i;
          size_d  = left_size_i;
          owner_d = left_owner_i;
        end
      end
      OP_FREE: begin
        if (sel_q) begin
          free_d  = 1'b1;
          owner_d = '0;
        end
      end
      OP_MERGE_PREV: begin
        // absorb the freed right neighbor, then close the gap
        if (right_sel_i) begin
          size_d = size_q + right_size_i;
        end
        if (sel_q || after_i) begin
          valid_d = right_valid_i;
          free_d  = right_free_i;
          start_d = right_start_i;
          size_d  = right_size_i;
          owner_d = right_owner_i;
        end
        sel_d = right_sel_i;
      end
      OP_MERGE_NEXT: begin
        if (sel_q) begin
          size_d = size_q + right_size_i;
        end
        if (after_i) begin
          valid_d = right_valid_i;
          free_d  = right_free_i;
          start_d = right_start_i;
          size_d  = right_size_i;
          owner_d = right_owner_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= FIRST;
      free_q  <= 1'b1;
      start_q <= '0;
      size_q  <= HEAP_RESET;
      owner_q <= '0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      free_q  <= free_d;
      start_q <= start_d;
      size_q  <= size_d;
      owner_q <= owner_d;
      sel_q   <= sel_d;
    end
  end

  assign valid_o = valid_q;
  assign free_o  = free_q;
  assign start_o = start_q;
  assign size_o  = size_q;
  assign owner_o = owner_q;
  assign sel_o   = sel_q;

endmodule

// ===== sv/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: request sequencer, APB
// register and the chain of segment cells. Depends on ffsa_pkg, ffsa_cell.
`timescale 1ns / 1ps

// The heap is an address-ordered row of MAX_SEGMENTS cells, one segment per
// cell, starting as a single free segment of heap_size units. A request is
// taken only while the sequencer is idle. An allocate runs through a search
// state, in which every cell compares in parallel and a ripple along the
// chain keeps the first hit, a decide state that marks or splits (a split
// shifts all later cells one place right in that same cycle), and a done
// state that loads the output register once it is free. A free runs the
// same search and decide, then a state to merge with a free predecessor and
// one to merge with a free successor, each a one-place left shift of the
// chain, then the output load. The output register holds a result until
// taken; the next item is accepted once the sequencer is back to idle.
// Writing heap_size (byte address 0) restarts the heap if the sequencer is
// idle, else it is ignored; write it only while no request is in flight.
module first_fit_segment_allocator import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [ADDR_BITS:0]   request_size_i,
  input  logic [ID_W-1:0]      free_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [ID_W-1:0]      block_id_o,
  output logic [ADDR_BITS-1:0] block_start_o,
  output logic [ADDR_BITS:0]   free_total_o
);

  localparam logic [ADDR_BITS:0] HEAP_RESET = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [32:0]        HEAP_LIMIT = 33'(HEAP_RESET);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_MERGE_P,
    S_MERGE_N,
    S_DONE
  } state_e;

  state_e               state_q;
  logic                 kind_q;
  logic [ADDR_BITS:0]   req_q;
  logic [ID_W-1:0]      fid_q;
  logic [2:0]           status_q;
  logic [ID_W-1:0]      id_q;
  logic [ADDR_BITS-1:0] start_q;
  logic [ADDR_BITS:0]   free_units_q;
  logic [ID_W-1:0]      next_owner_q;
  logic [ADDR_BITS:0]   heap_q;
  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [ID_W-1:0]      out_id_q;
  logic [ADDR_BITS-1:0] out_start_q;
  logic [ADDR_BITS:0]   out_free_q;

  cmd_t cmd;

  logic                 cfg_wr;
  logic [32:0]          wval;
  logic [ADDR_BITS:0]   heap_new;

  // chain signals
  logic                 c_valid [MAX_SEGMENTS];
  logic                 c_free  [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] c_start [MAX_SEGMENTS];
  logic [ADDR_BITS:0]   c_size  [MAX_SEGMENTS];
  logic [ID_W-1:0]      c_owner [MAX_SEGMENTS];
  logic                 c_sel   [MAX_SEGMENTS];
  logic                 c_after [MAX_SEGMENTS];
  logic                 c_found [MAX_SEGMENTS];

  logic                 any_sel, sel_free, prev_hit, next_hit, full;
  logic [ADDR_BITS-1:0] sel_start;
  logic [ADDR_BITS:0]   sel_size;

  assign pready = 1'b1;
  assign prdata = 32'(heap_q);
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  // clamp the written size to 1 .. 2^ADDR_BITS
  always_comb begin
    wval = {16'b0, pwdata[16:0]};
    if (wval == '0) begin
      heap_new = (ADDR_BITS + 1)'(1);
    end else if (wval > HEAP_LIMIT) begin
      heap_new = HEAP_RESET;
    end else begin
      heap_new = wval[ADDR_BITS:0];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      logic                 lv, lf, ls_sel, rv, rf, rs_sel, ai, fi;
      logic [ADDR_BITS-1:0] lst, rst;
      logic [ADDR_BITS:0]   lsz, rsz;
      logic [ID_W-1:0]      low, row;
      if (g == 0) begin : g_l0
        assign lv = 1'b0; assign lf = 1'b0; assign lst = '0; assign lsz = '0;
        assign low = '0; assign ls_sel = 1'b0; assign ai = 1'b0; assign fi = 1'b0;
      end else begin : g_ln
        assign lv = c_valid[g-1]; assign lf = c_free[g-1];
        assign lst = c_start[g-1]; assign lsz = c_size[g-1];
        assign low = c_owner[g-1]; assign ls_sel = c_sel[g-1];
        assign ai = c_after[g-1]; assign fi = c_found[g-1];
      end
      if (g == MAX_SEGMENTS - 1) begin : g_rl
        assign rv = 1'b0; assign rf = 1'b0; assign rst = '0; assign rsz = '0;
        assign row = '0; assign rs_sel = 1'b0;
      end else begin : g_rn
        assign rv = c_valid[g+1]; assign rf = c_free[g+1];
        assign rst = c_start[g+1]; assign rsz = c_size[g+1];
        assign row = c_owner[g+1]; assign rs_sel = c_sel[g+1];
      end
      ffsa_cell #(
        .ADDR_BITS(ADDR_BITS),
        .FIRST    (g == 0)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .cmd_i        (cmd),
        .req_i        (req_q),
        .heap_i       (heap_new),
        .left_valid_i (lv),
        .left_free_i  (lf),
        .left_start_i (lst),
        .left_size_i  (lsz),
        .left_owner_i (low),
        .left_sel_i   (ls_sel),
        .right_valid_i(rv),
        .right_free_i (rf),
        .right_start_i(rst),
        .right_size_i (rsz),
        .right_owner_i(row),
        .right_sel_i  (rs_sel),
        .after_i      (ai),
        .found_i      (fi),
        .valid_o      (c_valid[g]),
        .free_o       (c_free[g]),
        .start_o      (c_start[g]),
        .size_o       (c_size[g]),
        .owner_o      (c_owner[g]),
        .sel_o        (c_sel[g]),
        .after_o      (c_after[g]),
        .found_o      (c_found[g])
      );
    end
  endgenerate

  // gather the selected cell and its neighbors' free marks
  always_comb begin
    any_sel   = 1'b0;
    sel_free  = 1'b0;
    sel_start = '0;
    sel_size  = '0;
    prev_hit  = 1'b0;
    next_hit  = 1'b0;
    for (int j = 0; j < MAX_SEGMENTS; j++) begin
      any_sel   = any_sel | c_sel[j];
      sel_free  = sel_free | (c_sel[j] & c_free[j]);
      sel_start = sel_start | (c_sel[j] ? c_start[j] : '0);
      sel_size  = sel_size | (c_sel[j] ? c_size[j] : '0);
      if (j > 0) begin
        prev_hit = prev_hit | (c_sel[j] & c_free[j-1]);
      end
      if (j < MAX_SEGMENTS - 1) begin
        next_hit = next_hit | (c_sel[j] & c_valid[j+1] & c_free[j+1]);
      end
    end
  end

  assign full = c_valid[MAX_SEGMENTS-1];

  // command to the cell chain
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.kind  = kind_q;
    cmd.owner = next_owner_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_wr) begin
          cmd.op = OP_RESTART;
        end
      end
      S_SEARCH: begin
        cmd.op    = OP_SEARCH;
        cmd.owner = (kind_q == KIND_FREE) ? fid_q : '0;
      end
      S_DECIDE: begin
        if (kind_q == KIND_ALLOC) begin
          if ((req_q != '0) && any_sel) begin
            if (sel_size == req_q) begin
              cmd.op = OP_MARK;
            end else if (!full) begin
              cmd.op = OP_SPLIT;
            end
          end
        end else if (any_sel && !sel_free) begin
          cmd.op = OP_FREE;
        end
      end
      S_MERGE_P: begin
        if (prev_hit) begin
          cmd.op = OP_MERGE_PREV;
        end
      end
      S_MERGE_N: begin
        if (next_hit) begin
          cmd.op = OP_MERGE_NEXT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_ALLOC;
      req_q        <= '0;
      fid_q        <= '0;
      status_q     <= ST_OK;
      id_q         <= '0;
      start_q      <= '0;
      free_units_q <= HEAP_RESET;
      next_owner_q <= ID_W'(1);
      heap_q       <= HEAP_RESET;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_id_q     <= '0;
      out_start_q  <= '0;
      out_free_q   <= '0;
    end else begin
      // drop a taken result unless a new one is loaded below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_wr) begin
            heap_q       <= heap_new;
            free_units_q <= heap_new;
            next_owner_q <= ID_W'(1);
          end
          if (in_valid_i) begin
            kind_q  <= kind_i;
            req_q   <= request_size_i;
            fid_q   <= free_id_i;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (kind_q == KIND_ALLOC) begin
            state_q <= S_DONE;
            if (req_q == '0) begin
              status_q <= ST_BAD_SIZE;
              id_q     <= '0;
              start_q  <= '0;
            end else if (!any_sel) begin
              status_q <= ST_NO_MEMORY;
              id_q     <= '0;
              start_q  <= '0;
            end else if ((sel_size != req_q) && full) begin
              status_q <= ST_TABLE_FULL;
              id_q     <= '0;
              start_q  <= '0;
            end else begin
              status_q     <= ST_OK;
              id_q         <= next_owner_q;
              start_q      <= sel_start;
              free_units_q <= free_units_q - req_q;
              next_owner_q <= (next_owner_q == '1) ? ID_W'(1) : next_owner_q + 1'b1;
            end
          end else if (!any_sel) begin
            state_q  <= S_DONE;
            status_q <= ST_UNKNOWN_ID;
            id_q     <= '0;
            start_q  <= '0;
          end else if (sel_free) begin
            state_q  <= S_DONE;
            status_q <= ST_ALREADY_FREE;
            id_q     <= '0;
            start_q  <= '0;
          end else begin
            status_q     <= ST_OK;
            id_q         <= fid_q;
            start_q      <= sel_start;
            free_units_q <= free_units_q + sel_size;
            state_q      <= S_MERGE_P;
          end
        end
        S_MERGE_P: begin
          state_q <= S_MERGE_N;
        end
        S_MERGE_N: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output slot is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_id_q     <= id_q;
            out_start_q  <= start_q;
            out_free_q   <= free_units_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign block_id_o    = out_id_q;
  assign block_start_o = out_start_q;
  assign free_total_o  = out_free_q;

endmodule
